/* rtl/core/mvsa_pkg.sv */
// ----------------------------------------------------------------------------
// mvsa_pkg
// Shared types and constants for the MIDI voice slot allocator: slot table
// entry layout, command and error codes, message kinds and sequencer states.
// ----------------------------------------------------------------------------
package mvsa_pkg;

  localparam int SLOT_COUNT  = 32;
  localparam int SLOT_W      = $clog2(SLOT_COUNT);
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // command codes
  localparam logic [2:0] CMD_NOTE_ON    = 3'd0;
  localparam logic [2:0] CMD_NOTE_OFF   = 3'd1;
  localparam logic [2:0] CMD_KEY_PRESS  = 3'd2;
  localparam logic [2:0] CMD_CHAN_PRESS = 3'd3;
  localparam logic [2:0] CMD_BEND       = 3'd4;
  localparam logic [2:0] CMD_RETURN     = 3'd5;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_FULL     = 2'd1;
  localparam logic [1:0] ERR_NO_MATCH = 2'd2;

  // message kinds, high nibble of the status byte
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_PRESS    = 4'hA;
  localparam logic [3:0] KIND_BEND     = 4'hE;

  localparam logic [3:0]  DRUM_CHANNEL = 4'd9;
  localparam logic [13:0] BEND_OFFSET  = 14'h2000;

  typedef struct packed {
    logic       used;
    logic       sounding;
    logic [3:0] chan;
    logic [6:0] note;
  } slot_entry_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [4:0] slot;
    logic [6:0] data_one;
    logic [7:0] data_two;
    logic [1:0] error_code;
    logic       last;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FINISH
  } state_t;

endpackage

/* rtl/core/mvsa_slot_table.sv */
// ----------------------------------------------------------------------------
// mvsa_slot_table
// Voice slot table: synchronous memory with one read and one write port, registered read and
// per-entry valid bits, so an entry never written since reset reads as free.
// ----------------------------------------------------------------------------
module mvsa_slot_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [mvsa_pkg::SLOT_W-1:0] rd_addr,
  output mvsa_pkg::slot_entry_t       rd_data,
  input  logic                        wr_en,
  input  logic [mvsa_pkg::SLOT_W-1:0] wr_addr,
  input  mvsa_pkg::slot_entry_t       wr_data
);

  mvsa_pkg::slot_entry_t               mem [mvsa_pkg::SLOT_COUNT];
  logic [mvsa_pkg::SLOT_COUNT-1:0]     valid;
  mvsa_pkg::slot_entry_t               mem_q;
  logic                                vld_q;

  // payload array, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // valid bits clear at once on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= valid[rd_addr];
      end
    end
  end

  assign rd_data = vld_q ? mem_q : '0;

endmodule

/* rtl/core/midi_voice_slot_allocator.sv */
// ----------------------------------------------------------------------------
// midi_voice_slot_allocator
// Maps MIDI events onto synthesizer voice slots and sends 4-byte messages
// addressed by slot (status, slot, data one, data two).
// ----------------------------------------------------------------------------
// One item is worked on at a time. Note on, note off, key pressure and
// channel pressure scan the whole slot table through its single read port,
// with a read step and an evaluate step per slot, then a finish step that
// writes back and sends the result. Voice return reads only the reported
// slot; pitch bend and unknown commands go straight to the finish step.
// The finish step, and a channel pressure match while an item is held
// back, wait as long as the consumer still holds a result.
// Results come from an output register, so the consumer may stall freely.
// After reset the table reads as all free at once: per-slot valid bits are
// cleared, there is no clearing pass. in_ready stays low while rst is high.
// Channel pressure sends one item per slot on the channel, in slot order;
// last marks the final item of each input item. Errors (table full, note off
// without a sounding match) come as a single item with zero message bytes.
// ----------------------------------------------------------------------------
module midi_voice_slot_allocator (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         command,
  input  logic [3:0]         channel,
  input  logic [6:0]         note,
  input  logic signed [13:0] amount,
  input  logic [4:0]         returned_slot,
  input  logic [7:0]         drum_sample,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         status_byte,
  output logic [4:0]         slot,
  output logic [6:0]         data_one,
  output logic [7:0]         data_two,
  output logic [1:0]         error_code,
  output logic               last
);

  localparam logic [mvsa_pkg::SLOT_W-1:0] LAST_IDX =
    mvsa_pkg::SLOT_W'(mvsa_pkg::SLOT_COUNT - 1);

  mvsa_pkg::state_t state, state_next;

  // latched item
  logic [2:0]  cmd_q;
  logic [3:0]  chan_q;
  logic [6:0]  note_q;
  logic [13:0] amt_q;
  logic [4:0]  ret_q;
  logic [7:0]  drum_q;

  // scan position and first-hit candidates
  logic [mvsa_pkg::SLOT_W-1:0] idx;
  logic                        rel_hit, free_hit, snd_hit, key_hit;
  logic [mvsa_pkg::SLOT_W-1:0] rel_idx, free_idx, snd_idx, key_idx;
  mvsa_pkg::slot_entry_t       ret_ent;

  // channel pressure: one item held back so the final one can carry last
  logic                        pend_valid;
  logic [mvsa_pkg::SLOT_W-1:0] pend_slot;
  logic [6:0]                  pend_note;
  logic [mvsa_pkg::CNT_W-1:0]  res_cnt;

  // table port
  logic                        rd_en, wr_en;
  logic [mvsa_pkg::SLOT_W-1:0] wr_addr;
  mvsa_pkg::slot_entry_t       rd_data, wr_data;

  // result register load
  logic                        emit;
  mvsa_pkg::result_t           emit_res;

  logic accept, out_free;
  logic chan_match, note_match, cp_take, cp_stall;
  logic pick_hit, drum_missing, is_drum;
  logic [mvsa_pkg::SLOT_W-1:0] pick_idx;
  logic [13:0] bend_val;

  mvsa_slot_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign in_ready = (state == mvsa_pkg::S_IDLE) && !rst;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // entry under evaluation against the latched event
  assign chan_match = rd_data.used && (rd_data.chan == chan_q);
  assign note_match = chan_match && (rd_data.note == note_q);
  assign cp_take    = (cmd_q == mvsa_pkg::CMD_CHAN_PRESS) && chan_match &&
                      (res_cnt < mvsa_pkg::CNT_W'(mvsa_pkg::MAX_RESULTS));
  // a new match needs the held item pushed out first
  assign cp_stall   = cp_take && pend_valid && !out_free;

  assign pick_hit     = rel_hit || free_hit;
  assign pick_idx     = rel_hit ? rel_idx : free_idx;
  assign is_drum      = (chan_q == mvsa_pkg::DRUM_CHANNEL);
  assign drum_missing = is_drum && drum_q[7];
  // 14-bit two's complement plus offset: flip the sign bit
  assign bend_val     = amt_q ^ mvsa_pkg::BEND_OFFSET;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mvsa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state, table access and result load
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = idx;
    wr_data    = '0;
    emit       = 1'b0;
    emit_res   = '0;
    case (state)
      mvsa_pkg::S_IDLE: begin
        if (in_valid) begin
          case (command)
            mvsa_pkg::CMD_NOTE_ON, mvsa_pkg::CMD_NOTE_OFF,
            mvsa_pkg::CMD_KEY_PRESS, mvsa_pkg::CMD_CHAN_PRESS,
            mvsa_pkg::CMD_RETURN: state_next = mvsa_pkg::S_READ;
            default:              state_next = mvsa_pkg::S_FINISH;
          endcase
        end
      end
      mvsa_pkg::S_READ: begin
        rd_en      = 1'b1;
        state_next = mvsa_pkg::S_EVAL;
      end
      mvsa_pkg::S_EVAL: begin
        if (cmd_q == mvsa_pkg::CMD_RETURN) begin
          state_next = mvsa_pkg::S_FINISH;
        end else if (!cp_stall) begin
          if (cp_take && pend_valid) begin
            emit                 = 1'b1;
            emit_res.status_byte = {mvsa_pkg::KIND_PRESS, chan_q};
            emit_res.slot        = 5'(pend_slot);
            emit_res.data_one    = pend_note;
            emit_res.data_two    = amt_q[7:0];
            emit_res.error_code  = mvsa_pkg::ERR_NONE;
            emit_res.last        = 1'b0;
          end
          state_next = (idx == LAST_IDX) ? mvsa_pkg::S_FINISH : mvsa_pkg::S_READ;
        end
      end
      mvsa_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = mvsa_pkg::S_IDLE;
          case (cmd_q)
            mvsa_pkg::CMD_NOTE_ON: begin
              emit          = 1'b1;
              emit_res.last = 1'b1;
              if (!pick_hit) begin
                emit_res.error_code = mvsa_pkg::ERR_FULL;
              end else begin
                wr_en            = 1'b1;
                wr_addr          = pick_idx;
                wr_data.used     = 1'b1;
                wr_data.sounding = !drum_missing;
                wr_data.chan     = chan_q;
                wr_data.note     = note_q;
                // drum note without a sample: slot claimed, nothing sent
                emit                 = !drum_missing;
                emit_res.status_byte = {mvsa_pkg::KIND_NOTE_ON, chan_q};
                emit_res.slot        = 5'(pick_idx);
                emit_res.data_one    = is_drum ? drum_q[6:0] : note_q;
                emit_res.data_two    = {1'b0, amt_q[6:0]};
              end
            end
            mvsa_pkg::CMD_NOTE_OFF: begin
              emit          = 1'b1;
              emit_res.last = 1'b1;
              if (!snd_hit) begin
                emit_res.error_code = mvsa_pkg::ERR_NO_MATCH;
              end else begin
                wr_en                = 1'b1;
                wr_addr              = snd_idx;
                wr_data.used         = 1'b1;
                wr_data.sounding     = 1'b0;
                wr_data.chan         = chan_q;
                wr_data.note         = note_q;
                emit_res.status_byte = {mvsa_pkg::KIND_NOTE_OFF, chan_q};
                emit_res.slot        = 5'(snd_idx);
                emit_res.data_one    = note_q;
                emit_res.data_two    = {1'b0, amt_q[6:0]};
              end
            end
            mvsa_pkg::CMD_KEY_PRESS: begin
              emit                 = key_hit;
              emit_res.status_byte = {mvsa_pkg::KIND_PRESS, chan_q};
              emit_res.slot        = 5'(key_idx);
              emit_res.data_one    = note_q;
              emit_res.data_two    = {1'b0, amt_q[6:0]};
              emit_res.last        = 1'b1;
            end
            mvsa_pkg::CMD_CHAN_PRESS: begin
              emit                 = pend_valid;
              emit_res.status_byte = {mvsa_pkg::KIND_PRESS, chan_q};
              emit_res.slot        = 5'(pend_slot);
              emit_res.data_one    = pend_note;
              emit_res.data_two    = amt_q[7:0];
              emit_res.last        = 1'b1;
            end
            mvsa_pkg::CMD_BEND: begin
              emit                 = !is_drum;
              emit_res.status_byte = {mvsa_pkg::KIND_BEND, chan_q};
              emit_res.data_one    = {1'b0, bend_val[13:8]};
              emit_res.data_two    = bend_val[7:0];
              emit_res.last        = 1'b1;
            end
            mvsa_pkg::CMD_RETURN: begin
              // only a released slot inside the table goes back to free
              wr_en = (32'(ret_q) < mvsa_pkg::SLOT_COUNT) &&
                      ret_ent.used && !ret_ent.sounding;
            end
            default: ;
          endcase
        end
      end
      default: state_next = mvsa_pkg::S_IDLE;
    endcase
  end

  // item latch and scan bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      rel_hit    <= 1'b0;
      free_hit   <= 1'b0;
      snd_hit    <= 1'b0;
      key_hit    <= 1'b0;
      res_cnt    <= '0;
    end else if (accept) begin
      cmd_q      <= command;
      chan_q     <= channel;
      note_q     <= note;
      amt_q      <= amount;
      ret_q      <= returned_slot;
      drum_q     <= drum_sample;
      idx        <= (command == mvsa_pkg::CMD_RETURN) ?
                    mvsa_pkg::SLOT_W'(returned_slot) : '0;
      pend_valid <= 1'b0;
      rel_hit    <= 1'b0;
      free_hit   <= 1'b0;
      snd_hit    <= 1'b0;
      key_hit    <= 1'b0;
      res_cnt    <= '0;
    end else if (state == mvsa_pkg::S_EVAL) begin
      if (cmd_q == mvsa_pkg::CMD_RETURN) begin
        ret_ent <= rd_data;
      end else if (!cp_stall) begin
        if (!rel_hit && note_match && !rd_data.sounding) begin
          rel_hit <= 1'b1;
          rel_idx <= idx;
        end
        if (!free_hit && !rd_data.used) begin
          free_hit <= 1'b1;
          free_idx <= idx;
        end
        if (!snd_hit && note_match && rd_data.sounding) begin
          snd_hit <= 1'b1;
          snd_idx <= idx;
        end
        if (!key_hit && note_match) begin
          key_hit <= 1'b1;
          key_idx <= idx;
        end
        if (cp_take) begin
          pend_valid <= 1'b1;
          pend_slot  <= idx;
          pend_note  <= rd_data.note;
          res_cnt    <= res_cnt + 1'b1;
        end
        if (idx != LAST_IDX) begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status_byte <= emit_res.status_byte;
      slot        <= emit_res.slot;
      data_one    <= emit_res.data_one;
      data_two    <= emit_res.data_two;
      error_code  <= emit_res.error_code;
      last        <= emit_res.last;
    end
  end

endmodule

/* rtl/core/mvsa_checker.sv */
// ----------------------------------------------------------------------------
// mvsa_checker
// Port-level checks for the MIDI voice slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module mvsa_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] status_byte,
  input logic [4:0] slot,
  input logic [6:0] data_one,
  input logic [7:0] data_two,
  input logic [1:0] error_code,
  input logic       last
);

  // one item at a time: ready drops right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready still high after accept");

  // error items are single and carry no message bytes
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_code != mvsa_pkg::ERR_NONE) |->
      last && (status_byte == 8'd0) && (slot == 5'd0) &&
      (data_one == 7'd0) && (data_two == 8'd0))
    else $error("malformed error item");

  // pitch bend addresses slot zero and is always the only item
  a_bend_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status_byte[7:4] == mvsa_pkg::KIND_BEND) |->
      last && (slot == 5'd0) && !data_one[6])
    else $error("malformed pitch bend item");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(status_byte) && $stable(slot) && $stable(data_one) &&
      $stable(data_two) && $stable(error_code) && $stable(last))
    else $error("result changed while stalled");

endmodule

bind midi_voice_slot_allocator mvsa_checker u_mvsa_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status_byte (status_byte),
  .slot        (slot),
  .data_one    (data_one),
  .data_two    (data_two),
  .error_code  (error_code),
  .last        (last)
);
